// ===== src/wcrm_pkg.sv =====
// shared constants, codes and types for the window count rate meter
`default_nettype none

package wcrm_pkg;

   localparam int WINDOW        = 75;
   localparam int MARK_INTERVAL = 60;
   localparam int RATE_MAX      = 999999;
   localparam int SECS_PER_HOUR = 3600;

   localparam int ACT_W  = 2;
   localparam int CNT_W  = 16;
   localparam int RATE_W = 20;
   localparam int SEC_W  = 32;

   localparam int PTR_W   = $clog2(WINDOW);
   localparam int FILL_W  = $clog2(WINDOW + 1);
   localparam int RAW_SUM_W = CNT_W + $clog2(WINDOW);
   localparam int SUM_W   = (RAW_SUM_W > RATE_W) ? RAW_SUM_W : RATE_W + 1;
   localparam longint PULSE_LIMIT = (longint'(RATE_MAX) * SECS_PER_HOUR) / WINDOW;
   localparam int PULSE_W = $clog2(PULSE_LIMIT + 1);
   localparam int PH_W    = $clog2(MARK_INTERVAL + 1);

   // dose = floor(pulses * WINDOW / 3600), 3600 = 16 * 225
   localparam int PROD_W         = 32;
   localparam int DOSE_PRE_SHIFT = 4;
   localparam int DOSE_DIV_ODD   = SECS_PER_HOUR >> DOSE_PRE_SHIFT;
   localparam int DIV_ODD_W      = $clog2(DOSE_DIV_ODD + 1);
   localparam int DOSE_X_W       = PROD_W - DOSE_PRE_SHIFT;
   localparam int DOSE_SHIFT     = DOSE_X_W + DIV_ODD_W;
   localparam longint DOSE_RECIP = (longint'(1) << DOSE_SHIFT) / DOSE_DIV_ODD;
   localparam int RECIP_W        = DOSE_SHIFT - DIV_ODD_W + 1;
   localparam int QUOT_W         = DOSE_X_W - DIV_ODD_W + 1;
   localparam int MUL_W          = DOSE_X_W + RECIP_W;

   typedef logic [ACT_W-1:0]  action_type;
   typedef logic [RATE_W-1:0] rate_type;

   localparam action_type ACT_TICK       = 2'd0;
   localparam action_type ACT_CLR_RATE   = 2'd1;
   localparam action_type ACT_CLR_TOTALS = 2'd2;

endpackage

`default_nettype wire

// ===== src/window_count_rate_meter.sv =====
// top level of the window count rate meter
`default_nettype none

// Takes one transaction per clock while req_stall is low and gives one result
// transaction per transaction, in order, through the s1, s2, s3, s4 and output
// registers. Each transaction is a one-second tick carrying a pulse count, a
// rate clear or a totals clear. The last WINDOW counts sit in a ring memory
// with one read port (used at acceptance for the oldest count) and one write
// port (used from the s1 registers when the pipeline advances); the running
// sum, peak, session pulses and seconds live in registers. The dose division
// by 3600 is a reciprocal multiply with a one-step correction over two
// pipeline stages. Ring entries are never used before they are written, so no
// clearing pass is needed after reset. req_stall follows rsp_stall while a
// result waits in the output register.

module window_count_rate_meter
   import wcrm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [ACT_W-1:0] req_action,
   input  wire logic [CNT_W-1:0] req_pulse_count,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [RATE_W-1:0]     rsp_rate,
   output logic [RATE_W-1:0]     rsp_peak_rate,
   output logic [RATE_W-1:0]     rsp_session_dose,
   output logic [SEC_W-1:0]      rsp_session_seconds,
   output logic                  rsp_minute_mark
);

   logic advance;
   logic accept;

   logic [CNT_W-1:0]   ring_mem [WINDOW];
   logic [CNT_W-1:0]   rd_data_ff;

   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   logic               s1_valid_ff;
   action_type         s1_action_ff;
   logic [CNT_W-1:0]   s1_count_ff;
   logic [PTR_W-1:0]   s1_slot_ff;
   logic               s1_oldest_ff;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PULSE_W-1:0] pulses_ff, pulses_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [CNT_W-1:0]   old_c;
   logic [PULSE_W:0]   pulse_sum_c;
   logic [PH_W-1:0]    phase_inc_c;
   logic               mark_c;

   logic               s2_valid_ff;
   action_type         s2_action_ff;
   logic [SUM_W-1:0]   s2_sum_ff;
   logic [PULSE_W-1:0] s2_pulses_ff;
   logic [SEC_W-1:0]   s2_sec_ff;
   logic               s2_mark_ff;

   rate_type           rate_c;
   rate_type           peak_ff, peak_in;
   logic [PROD_W-1:0]  prod_c;

   logic               s3_valid_ff;
   rate_type           s3_rate_ff;
   rate_type           s3_peak_ff;
   logic [SEC_W-1:0]   s3_sec_ff;
   logic               s3_mark_ff;
   logic [PROD_W-1:0]  s3_prod_ff;

   logic               s4_valid_ff;
   rate_type           s4_rate_ff;
   rate_type           s4_peak_ff;
   logic [SEC_W-1:0]   s4_sec_ff;
   logic               s4_mark_ff;
   rate_type           dose_c;

   logic               out_valid_ff;
   rate_type           out_rate_ff;
   rate_type           out_peak_ff;
   rate_type           out_dose_ff;
   logic [SEC_W-1:0]   out_sec_ff;
   logic               out_mark_ff;

   assign advance   = !(out_valid_ff && rsp_stall);
   assign accept    = req_valid && advance;
   assign req_stall = !advance;

   // front: ring pointer and fill level
   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      if (accept) begin
         unique case (req_action)
            ACT_TICK: begin
               ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
               if (fill_ff != FILL_W'(WINDOW)) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
            ACT_CLR_RATE: begin
               ptr_in  = '0;
               fill_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
         if (advance) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_count_ff  <= req_pulse_count;
         s1_slot_ff   <= ptr_ff;
         s1_oldest_ff <= (fill_ff == FILL_W'(WINDOW));
      end
   end

   // ring memory: read at acceptance, write back from the s1 registers when the pipeline advances
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= ring_mem[ptr_ff];
      end
      if (advance && s1_valid_ff && (s1_action_ff == ACT_TICK)) begin
         ring_mem[s1_slot_ff] <= s1_count_ff;
      end
   end

   // window sum, session pulses and seconds
   always_comb begin
      sum_in      = sum_ff;
      pulses_in   = pulses_ff;
      sec_in      = sec_ff;
      phase_in    = phase_ff;
      mark_c      = 1'b0;
      old_c       = s1_oldest_ff ? rd_data_ff : '0;
      pulse_sum_c = (PULSE_W+1)'(pulses_ff) + (PULSE_W+1)'(s1_count_ff);
      phase_inc_c = phase_ff + 1'b1;
      if (advance && s1_valid_ff) begin
         unique case (s1_action_ff)
            ACT_TICK: begin
               sum_in = sum_ff - SUM_W'(old_c) + SUM_W'(s1_count_ff);
               pulses_in = (pulse_sum_c > (PULSE_W+1)'(PULSE_LIMIT)) ?
                           PULSE_W'(PULSE_LIMIT) : pulse_sum_c[PULSE_W-1:0];
               if (sec_ff == '1) begin
                  sec_in   = '0;
                  phase_in = '0;
               end else begin
                  sec_in   = sec_ff + 1'b1;
                  phase_in = (phase_inc_c == PH_W'(MARK_INTERVAL)) ? '0 : phase_inc_c;
               end
               mark_c = (phase_in == '0);
            end
            ACT_CLR_RATE: begin
               sum_in = '0;
            end
            ACT_CLR_TOTALS: begin
               pulses_in = '0;
               sec_in    = '0;
               phase_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         pulses_ff   <= '0;
         sec_ff      <= '0;
         phase_ff    <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         pulses_ff <= pulses_in;
         sec_ff    <= sec_in;
         phase_ff  <= phase_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_action_ff <= s1_action_ff;
         s2_sum_ff    <= sum_in;
         s2_pulses_ff <= pulses_in;
         s2_sec_ff    <= sec_in;
         s2_mark_ff   <= mark_c;
      end
   end

   // saturated rate, peak and dose product
   assign rate_c = (s2_sum_ff > SUM_W'(RATE_MAX)) ? RATE_W'(RATE_MAX) : s2_sum_ff[RATE_W-1:0];
   assign prod_c = PROD_W'(s2_pulses_ff) * PROD_W'(WINDOW);

   always_comb begin
      peak_in = peak_ff;
      if (advance && s2_valid_ff) begin
         unique case (s2_action_ff)
            ACT_TICK: begin
               if (rate_c > peak_ff) begin
                  peak_in = rate_c;
               end
            end
            ACT_CLR_RATE: begin
               peak_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         peak_ff <= peak_in;
         if (advance) begin
            s3_valid_ff  <= s2_valid_ff;
            s4_valid_ff  <= s3_valid_ff;
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_rate_ff  <= rate_c;
         s3_peak_ff  <= peak_in;
         s3_sec_ff   <= s2_sec_ff;
         s3_mark_ff  <= s2_mark_ff;
         s3_prod_ff  <= prod_c;
         s4_rate_ff  <= s3_rate_ff;
         s4_peak_ff  <= s3_peak_ff;
         s4_sec_ff   <= s3_sec_ff;
         s4_mark_ff  <= s3_mark_ff;
         out_rate_ff <= s4_rate_ff;
         out_peak_ff <= s4_peak_ff;
         out_dose_ff <= dose_c;
         out_sec_ff  <= s4_sec_ff;
         out_mark_ff <= s4_mark_ff;
      end
   end

   wcrm_dose_div dose_div (
      .clock   (clock),
      .advance (advance),
      .product (s3_prod_ff),
      .dose    (dose_c)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_rate            = out_rate_ff;
   assign rsp_peak_rate       = out_peak_ff;
   assign rsp_session_dose    = out_dose_ff;
   assign rsp_session_seconds = out_sec_ff;
   assign rsp_minute_mark     = out_mark_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("ring fill level beyond window");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ptr_ff} < (PTR_W+1)'(WINDOW))
      else $error("ring pointer beyond window");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PH_W'(MARK_INTERVAL))
      else $error("minute phase out of range");

   a_peak_covers_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_rate >= rsp_rate))
      else $error("peak below current rate");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("transaction taken while result held");

endmodule

`default_nettype wire

// ===== src/wcrm_dose_div.sv =====
// two-stage constant divider: session dose from pulses times window
`default_nettype none

module wcrm_dose_div
   import wcrm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [PROD_W-1:0] product,
   output rate_type               dose
);

   logic [DOSE_X_W-1:0]          x_c;
   logic [MUL_W-1:0]             mul_c;
   logic [DOSE_X_W-1:0]          x_ff;
   logic [QUOT_W-1:0]            q0_ff;
   logic [QUOT_W+DIV_ODD_W-1:0]  back_c;
   logic [DOSE_X_W-1:0]          rem_c;
   logic [QUOT_W-1:0]            quot_c;

   assign x_c   = product[PROD_W-1:DOSE_PRE_SHIFT];
   assign mul_c = MUL_W'(x_c) * MUL_W'(DOSE_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff  <= x_c;
         q0_ff <= mul_c[DOSE_SHIFT +: QUOT_W];
      end
   end

   // reciprocal estimate is exact or one low
   assign back_c = (QUOT_W+DIV_ODD_W)'(q0_ff) * (QUOT_W+DIV_ODD_W)'(DOSE_DIV_ODD);
   assign rem_c  = x_ff - back_c[DOSE_X_W-1:0];
   assign quot_c = (rem_c >= DOSE_X_W'(DOSE_DIV_ODD)) ? q0_ff + 1'b1 : q0_ff;
   assign dose   = (quot_c > QUOT_W'(RATE_MAX)) ? RATE_W'(RATE_MAX) : quot_c[RATE_W-1:0];

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the window count rate meter: random ticks, clears and stalls
module tb_top;
   import wcrm_pkg::*;

   typedef struct {
      action_type       action;
      logic [CNT_W-1:0] count;
      bit               drain_first;
   } meter_req_type;

   typedef struct {
      rate_type         rate;
      rate_type         peak;
      rate_type         dose;
      logic [SEC_W-1:0] seconds;
      logic             mark;
   } meter_reading_type;

   localparam action_type ACT_UNUSED   = 2'd3;
   localparam int         MAX_GAP      = 12;
   localparam int         MIXED_ITEMS  = 40;
   localparam int         SUSTAIN_ITEMS = 760;
   localparam int         TAIL_CYCLES  = 20;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   wire logic             req_stall;
   logic [ACT_W-1:0]      req_action      = ACT_TICK;
   logic [CNT_W-1:0]      req_pulse_count = '0;
   wire logic             rsp_valid;
   logic                  rsp_stall       = 1'b0;
   wire logic [RATE_W-1:0] rsp_rate;
   wire logic [RATE_W-1:0] rsp_peak_rate;
   wire logic [RATE_W-1:0] rsp_session_dose;
   wire logic [SEC_W-1:0]  rsp_session_seconds;
   wire logic              rsp_minute_mark;

   window_count_rate_meter u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_pulse_count     (req_pulse_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rate            (rsp_rate),
      .rsp_peak_rate       (rsp_peak_rate),
      .rsp_session_dose    (rsp_session_dose),
      .rsp_session_seconds (rsp_session_seconds),
      .rsp_minute_mark     (rsp_minute_mark)
   );

   meter_req_type     tick_queue[$];
   meter_reading_type due_readings[$];
   int                mismatches = 0;

   // predicted meter state
   int               ring_hist [WINDOW];
   int               hist_ptr    = 0;
   int               hist_fill   = 0;
   int               hist_sum    = 0;
   int               peak_seen   = 0;
   longint           pulse_total = 0;
   logic [SEC_W-1:0] sec_count   = '0;

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      $display("%0t %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   task automatic meter_predict(input meter_req_type it);
      meter_reading_type r;
      int                oldest;
      int                rate_now;
      longint            dose;
      oldest = 0;
      r.mark = 1'b0;
      case (it.action)
         ACT_TICK: begin
            if (hist_fill >= WINDOW) begin
               oldest = ring_hist[hist_ptr];
            end else begin
               hist_fill++;
            end
            hist_sum = hist_sum - oldest + int'(it.count);
            ring_hist[hist_ptr] = int'(it.count);
            hist_ptr = (hist_ptr + 1 >= WINDOW) ? 0 : hist_ptr + 1;
            rate_now = (hist_sum > RATE_MAX) ? RATE_MAX : hist_sum;
            if (rate_now > peak_seen) peak_seen = rate_now;
            pulse_total = pulse_total + longint'(it.count);
            if (pulse_total > PULSE_LIMIT) pulse_total = PULSE_LIMIT;
            sec_count = sec_count + 1'b1;
            r.mark = ((sec_count % MARK_INTERVAL) == 0);
         end
         ACT_CLR_RATE: begin
            hist_fill = 0;
            hist_ptr  = 0;
            hist_sum  = 0;
            peak_seen = 0;
         end
         ACT_CLR_TOTALS: begin
            pulse_total = 0;
            sec_count   = '0;
         end
         default: ;
      endcase
      rate_now = (hist_sum > RATE_MAX) ? RATE_MAX : hist_sum;
      dose = pulse_total * WINDOW / SECS_PER_HOUR;
      if (dose > RATE_MAX) dose = RATE_MAX;
      r.rate    = RATE_W'(rate_now);
      r.peak    = RATE_W'(peak_seen);
      r.dose    = RATE_W'(dose);
      r.seconds = sec_count;
      due_readings.push_back(r);
   endtask

   function automatic logic [CNT_W-1:0] draw_count(input bit heavy);
      int pick;
      pick = $urandom_range(0, 99);
      if (heavy) begin
         return (pick < 99) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      end
      if (pick < 25) return 16'($urandom_range(0, 15));
      if (pick < 40) return 16'($urandom_range(65520, 65535));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic queue_item(input action_type act, input logic [CNT_W-1:0] cnt,
                             input bit drain);
      meter_req_type it;
      it.action      = act;
      it.count       = cnt;
      it.drain_first = drain;
      tick_queue.push_back(it);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   meter_req_type cur_item;
   int            send_hold  = 0;
   bit            send_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            meter_predict(cur_item);
         end
         if (!req_valid || !req_stall) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0 &&
                         !(tick_queue[0].drain_first && due_readings.size() != 0)) begin
               cur_item        = tick_queue.pop_front();
               req_valid       <= 1'b1;
               req_action      <= cur_item.action;
               req_pulse_count <= cur_item.count;
               if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
               send_hold = send_burst ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   meter_reading_type want;
   int                stall_left = 0;
   bit                recv_burst = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_readings.size() == 0) begin
               flag_mismatch("result with nothing pending, rate", rsp_rate, 0);
            end else begin
               want = due_readings.pop_front();
               if (rsp_rate != want.rate)
                  flag_mismatch("rate", rsp_rate, want.rate);
               if (rsp_peak_rate != want.peak)
                  flag_mismatch("peak_rate", rsp_peak_rate, want.peak);
               if (rsp_session_dose != want.dose)
                  flag_mismatch("session_dose", rsp_session_dose, want.dose);
               if (rsp_session_seconds != want.seconds)
                  flag_mismatch("session_seconds", rsp_session_seconds, want.seconds);
               if (rsp_minute_mark != want.mark)
                  flag_mismatch("minute_mark", rsp_minute_mark, want.mark);
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int         pick;
      action_type act;

      // directed
      queue_item(ACT_UNUSED, 16'h0000, 1'b0);
      queue_item(ACT_CLR_RATE, 16'h0000, 1'b0);
      queue_item(ACT_CLR_TOTALS, 16'h0000, 1'b0);
      queue_item(ACT_TICK, 16'h0000, 1'b0);
      queue_item(ACT_TICK, 16'hFFFF, 1'b0);
      queue_item(ACT_TICK, 16'h0001, 1'b0);
      queue_item(ACT_TICK, 16'hAAAA, 1'b0);
      queue_item(ACT_TICK, 16'h5555, 1'b0);
      queue_item(ACT_UNUSED, 16'hFFFF, 1'b0);
      queue_item(ACT_CLR_RATE, 16'hFFFF, 1'b0);
      queue_item(ACT_TICK, 16'd100, 1'b0);
      queue_item(ACT_CLR_TOTALS, 16'hFFFF, 1'b0);
      queue_item(ACT_TICK, 16'd7, 1'b0);
      queue_item(ACT_CLR_RATE, 16'h0000, 1'b0);
      queue_item(ACT_CLR_RATE, 16'h0000, 1'b0);
      queue_item(ACT_TICK, 16'hFFFE, 1'b0);
      queue_item(ACT_CLR_TOTALS, 16'h0000, 1'b0);
      queue_item(ACT_CLR_TOTALS, 16'h0000, 1'b0);
      queue_item(ACT_TICK, 16'h8000, 1'b0);

      // mixed traffic with frequent clears
      for (int i = 0; i < MIXED_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) act = ACT_TICK;
         else if (pick < 84) act = ACT_CLR_RATE;
         else if (pick < 95) act = ACT_CLR_TOTALS;
         else act = ACT_UNUSED;
         queue_item(act, draw_count(1'b0), i == 0);
      end

      // sustained high rate: window wraps, rate and session totals saturate
      for (int i = 0; i < SUSTAIN_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 98) act = ACT_TICK;
         else if (pick < 99) act = ACT_CLR_RATE;
         else act = ACT_UNUSED;
         queue_item(act, draw_count(1'b1), i == 0);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (tick_queue.size() != 0 || req_valid) @(negedge clock);
      while (due_readings.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("window_count_rate_meter: match");
      end else begin
         $display("window_count_rate_meter: mismatch");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("window_count_rate_meter: mismatch");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/wcrm_pkg.sv
src/wcrm_dose_div.sv
src/window_count_rate_meter.sv
bench/tb_top.sv
